// ===== hdl/tpdt_pkg.sv =====
package tpdt_pkg;

    localparam int TRACKS_DEF = 64;
    localparam int TIME_W     = 48;
    localparam int HIT_W      = 16;
    localparam int ID_W       = 6;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [HIT_W-1:0] HIT_MAX = '1;

    localparam logic [CFG_W-1:0] ROT_RST    = 16'd1000;
    localparam logic [CFG_W-1:0] MISS_RST   = 16'd2000;
    localparam logic [CFG_W-1:0] PROM_RST   = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_ROT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROM = 2'd2;

    localparam logic [1:0] FLAG_NEW  = 2'd0;
    localparam logic [1:0] FLAG_CORR = 2'd1;

    localparam logic ACT_PROMOTE = 1'b0;
    localparam logic ACT_DROP    = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [HIT_W-1:0]  hits;
        logic [TIME_W-1:0] ltime;
        logic              kind;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// ===== hdl/tpdt_cell.sv =====
module tpdt_cell #(
    parameter int IDX    = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [tpdt_pkg::ID_W-1:0]       i_wr_idx,
    input  logic [tpdt_pkg::TIME_W-1:0]     i_wr_time,
    input  logic                            i_wr_kind,
    input  logic                            i_shift,
    input  tpdt_pkg::t_entry                i_next,
    output tpdt_pkg::t_entry                o_entry
);
    tpdt_pkg::t_entry r_ent, n_ent;

    // pass the neighbor's entry along while shifting, else update on a message for this cell
    always_comb begin
        n_ent = r_ent;
        if (i_shift) begin
            n_ent = i_next;
        end else if (i_wr_en && (i_wr_idx == tpdt_pkg::ID_W'(IDX))) begin
            n_ent.valid = 1'b1;
            if (!r_ent.valid) begin
                n_ent.hits = tpdt_pkg::HIT_W'(1);
            end else if (r_ent.hits != tpdt_pkg::HIT_MAX) begin
                n_ent.hits = r_ent.hits + 1'b1;
            end
            n_ent.ltime = i_wr_time;
            n_ent.kind  = i_wr_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
        end
        r_ent.hits  <= n_ent.hits;
        r_ent.ltime <= n_ent.ltime;
        r_ent.kind  <= n_ent.kind;
    end

    assign o_entry = r_ent;
endmodule

// ===== hdl/track_promote_drop_table.sv =====
// Track message: busy stays low; one message per cycle while no check tick is busy.
// Check tick: busy from the accepting edge while entries rotate once through the cell
// ring, one per cycle (ST_SCAN), then ST_DONE closes out; next request once busy is low.
// Each report is held until the next reporting entry is evaluated and shows next cycle;
// the last one shows in the first cycle with busy low. The receiver cannot stall.
// Sync active-low reset clears valid bits, offset, state, strobe; loads config defaults.
module track_promote_drop_table #(
    parameter int TRACKS = tpdt_pkg::TRACKS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_mode,
    input  logic [tpdt_pkg::ID_W-1:0]           i_track_id,
    input  logic                                i_track_kind,
    input  logic [1:0]                          i_msg_flag,
    input  logic [tpdt_pkg::TIME_W-1:0]         i_extract_ms,
    input  logic [tpdt_pkg::TIME_W-1:0]         i_wall_ms,
    input  logic                                i_cfg_we,
    input  logic [tpdt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tpdt_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                o_strobe,
    output logic [tpdt_pkg::ID_W-1:0]           o_report_track,
    output logic                                o_report_action,
    output logic                                o_report_kind,
    output logic [tpdt_pkg::TIME_W-1:0]         o_report_time,
    output logic                                o_last_report
);
    localparam int CW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int TW = tpdt_pkg::TIME_W;

    tpdt_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [tpdt_pkg::CFG_W-1:0] r_rot, r_miss, r_prom;
    logic signed [TW:0]   r_offset;
    logic signed [TW+1:0] r_base;
    logic [2*tpdt_pkg::CFG_W-1:0] r_limit;

    // pending report, held until we know whether another follows
    logic                  r_pv, n_pv;
    logic [CW-1:0]         r_pid, n_pid;
    logic                  r_pact, n_pact;
    logic                  r_pkind, n_pkind;
    logic [TW-1:0]         r_ptime, n_ptime;

    logic                  n_strobe, n_last, n_act, n_kind;
    logic [CW-1:0]         n_id;
    logic [TW-1:0]         n_time;

    logic accept, msg_ok, shift;
    tpdt_pkg::t_entry ent [TRACKS];
    tpdt_pkg::t_entry head, tail;
    logic signed [TW+2:0] age;
    logic drop, prom;

    assign accept = start && !busy;
    assign msg_ok = accept && !i_mode
                    && (i_msg_flag == tpdt_pkg::FLAG_NEW || i_msg_flag == tpdt_pkg::FLAG_CORR)
                    && ({1'b0, i_track_id} < (tpdt_pkg::ID_W+1)'(TRACKS));
    assign shift  = (r_state == tpdt_pkg::ST_SCAN);
    assign busy   = (r_state != tpdt_pkg::ST_IDLE);

    // evaluate the head cell
    assign head = ent[0];
    assign age  = {r_base[TW+1], r_base} - (TW+3)'({1'b0, head.ltime});
    assign drop = head.valid && (age > $signed((TW+3)'(r_limit)));
    assign prom = head.valid && !head.kind && (head.hits >= r_prom);
    always_comb begin
        tail       = head;
        tail.valid = head.valid && !drop;
    end

    // cell ring
    for (genvar k = 0; k < TRACKS; k++) begin : g_cell
        tpdt_pkg::t_entry nxt;
        if (k == TRACKS - 1) begin : g_tail
            assign nxt = tail;
        end else begin : g_mid
            assign nxt = ent[k+1];
        end
        tpdt_cell #(.IDX(k)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (msg_ok),
            .i_wr_idx  (i_track_id),
            .i_wr_time (i_extract_ms),
            .i_wr_kind (i_track_kind),
            .i_shift   (shift),
            .i_next    (nxt),
            .o_entry   (ent[k])
        );
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pv     = r_pv;
        n_pid    = r_pid;
        n_pact   = r_pact;
        n_pkind  = r_pkind;
        n_ptime  = r_ptime;
        n_strobe = 1'b0;
        n_last   = 1'b0;
        n_id     = r_pid;
        n_act    = r_pact;
        n_kind   = r_pkind;
        n_time   = r_ptime;
        unique case (r_state)
            tpdt_pkg::ST_IDLE: begin
                if (accept && i_mode) begin
                    n_state = tpdt_pkg::ST_SCAN;
                    n_cnt   = '0;
                    n_pv    = 1'b0;
                end
            end
            tpdt_pkg::ST_SCAN: begin
                if (drop || prom) begin
                    n_strobe = r_pv;
                    n_pv     = 1'b1;
                    n_pid    = r_cnt;
                    n_pact   = drop ? tpdt_pkg::ACT_DROP : tpdt_pkg::ACT_PROMOTE;
                    n_pkind  = head.kind;
                    n_ptime  = head.ltime;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(TRACKS - 1)) begin
                    n_state = tpdt_pkg::ST_DONE;
                end
            end
            tpdt_pkg::ST_DONE: begin
                n_strobe = r_pv;
                n_last   = 1'b1;
                n_pv     = 1'b0;
                n_state  = tpdt_pkg::ST_IDLE;
            end
            default: n_state = tpdt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tpdt_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            o_strobe <= 1'b0;
            r_offset <= '0;
            r_rot    <= tpdt_pkg::ROT_RST;
            r_miss   <= tpdt_pkg::MISS_RST;
            r_prom   <= tpdt_pkg::PROM_RST;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pv     <= n_pv;
            o_strobe <= n_strobe;
            if (msg_ok) begin
                r_offset <= $signed({1'b0, i_wall_ms}) - $signed({1'b0, i_extract_ms});
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tpdt_pkg::REG_ROT:  r_rot  <= i_cfg_data;
                    tpdt_pkg::REG_MISS: r_miss <= i_cfg_data;
                    tpdt_pkg::REG_PROM: r_prom <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // tick constants and report payload
    always_ff @(posedge i_clk) begin
        if (accept && i_mode) begin
            r_base  <= $signed({2'b00, i_wall_ms}) - {r_offset[TW], r_offset};
            r_limit <= r_rot * r_miss;
        end
        r_pid           <= n_pid;
        r_pact          <= n_pact;
        r_pkind         <= n_pkind;
        r_ptime         <= n_ptime;
        o_report_track  <= tpdt_pkg::ID_W'(n_id);
        o_report_action <= n_act;
        o_report_kind   <= n_kind;
        o_report_time   <= n_time;
        o_last_report   <= n_last;
    end

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode) |=> busy)
        else $error("tick did not start scan");
    a_last_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_report) |=> !o_strobe)
        else $error("report after final report");
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !busy))
        else $error("activity after reset");
    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tpdt_pkg::ST_DONE) |=> !busy)
        else $error("scan did not close");
endmodule

// ===== test/track_promote_drop_table_test.sv =====
module track_promote_drop_table_test;

    typedef struct packed {
        logic                        mode;
        logic [tpdt_pkg::ID_W-1:0]   id;
        logic                        kind;
        logic [1:0]                  flag;
        logic [tpdt_pkg::TIME_W-1:0] extract;
        logic [tpdt_pkg::TIME_W-1:0] wall;
    } t_request;

    typedef struct packed {
        logic [tpdt_pkg::ID_W-1:0]   track;
        logic                        action;
        logic                        kind;
        logic [tpdt_pkg::TIME_W-1:0] rtime;
        logic                        last;
    } t_report;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_mode = 1'b0;
    logic [tpdt_pkg::ID_W-1:0] i_track_id = '0;
    logic i_track_kind = 1'b0;
    logic [1:0] i_msg_flag = '0;
    logic [tpdt_pkg::TIME_W-1:0] i_extract_ms = '0;
    logic [tpdt_pkg::TIME_W-1:0] i_wall_ms = '0;
    logic i_cfg_we = 1'b0;
    logic [tpdt_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [tpdt_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic o_strobe;
    logic [tpdt_pkg::ID_W-1:0] o_report_track;
    logic o_report_action;
    logic o_report_kind;
    logic [tpdt_pkg::TIME_W-1:0] o_report_time;
    logic o_last_report;

    track_promote_drop_table dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [tpdt_pkg::CFG_W-1:0] rot_q, miss_q, prom_q;
    logic tbl_valid [tpdt_pkg::TRACKS_DEF];
    logic [tpdt_pkg::HIT_W-1:0] tbl_hits [tpdt_pkg::TRACKS_DEF];
    logic [tpdt_pkg::TIME_W-1:0] tbl_time [tpdt_pkg::TRACKS_DEF];
    logic tbl_kind [tpdt_pkg::TRACKS_DEF];
    logic signed [49:0] offset_q;

    t_request pending_q[$];
    t_report  reports_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_reports = 0;
    int n_ticks = 0;
    int cycles = 0;
    bit quiet = 0;
    bit cfg_active = 0;
    int gap = 0;

    // append one request to the pending queue
    task automatic add_req(input t_request r);
        pending_q.insert(pending_q.size(), r);
    endtask

    // apply one request to the table and queue the reports it causes
    task automatic predict_request(input t_request r);
        logic signed [63:0] age, lim;
        logic drop, prom;
        int first, i;
        t_report rep;
        if (r.mode == 1'b0) begin
            if (r.flag == tpdt_pkg::FLAG_NEW || r.flag == tpdt_pkg::FLAG_CORR) begin
                if (!tbl_valid[r.id]) begin
                    tbl_valid[r.id] = 1'b1;
                    tbl_hits[r.id] = 16'd1;
                end else if (tbl_hits[r.id] != tpdt_pkg::HIT_MAX) begin
                    tbl_hits[r.id] = tbl_hits[r.id] + 16'd1;
                end
                tbl_time[r.id] = r.extract;
                tbl_kind[r.id] = r.kind;
                offset_q = $signed({2'b0, r.wall}) - $signed({2'b0, r.extract});
            end
            return;
        end
        n_ticks++;
        first = reports_q.size();
        lim = $signed({32'b0, 32'(rot_q) * 32'(miss_q)});
        for (i = 0; i < tpdt_pkg::TRACKS_DEF; i++) begin
            if (tbl_valid[i]) begin
                age = $signed({16'b0, r.wall})
                      - (64'(offset_q) + $signed({16'b0, tbl_time[i]}));
                drop = age > lim;
                prom = !tbl_kind[i] && tbl_hits[i] >= prom_q;
                if (drop || prom) begin
                    rep = {6'(i), drop ? tpdt_pkg::ACT_DROP : tpdt_pkg::ACT_PROMOTE,
                           tbl_kind[i], tbl_time[i], 1'b0};
                    reports_q.insert(reports_q.size(), rep);
                end
                if (drop) tbl_valid[i] = 1'b0;
            end
        end
        if (reports_q.size() > first) reports_q[reports_q.size()-1].last = 1'b1;
    endtask

    // drive requests from the pending queue with random idle bursts
    always @(posedge i_clk) begin
        if (i_rst_n && !(start && busy)) begin
            if (start) begin
                predict_request({i_mode, i_track_id, i_track_kind, i_msg_flag,
                                 i_extract_ms, i_wall_ms});
                n_sent++;
            end
            if (gap > 0) begin
                gap <= gap - 1;
                start <= 1'b0;
            end else if (pending_q.size() > 0 && !cfg_active) begin
                t_request r;
                r = pending_q.pop_front();
                start <= 1'b1;
                {i_mode, i_track_id, i_track_kind, i_msg_flag, i_extract_ms, i_wall_ms} <= r;
                if (!quiet && $urandom_range(0, 5) == 0) gap <= $urandom_range(1, 14);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // compare each report with the oldest prediction
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) begin
            t_report act, exp_r;
            act = {o_report_track, o_report_action, o_report_kind, o_report_time,
                   o_last_report};
            n_reports++;
            if (reports_q.size() == 0) begin
                errors++;
                $display("%0t unexpected report: expected none actual %h", $time, act);
            end else begin
                exp_r = reports_q.pop_front();
                if (exp_r.track != act.track)
                    $display("%0t track mismatch: expected %0d actual %0d",
                             $time, exp_r.track, act.track);
                if (exp_r.action != act.action)
                    $display("%0t action mismatch: expected %0d actual %0d",
                             $time, exp_r.action, act.action);
                if (exp_r.kind != act.kind)
                    $display("%0t kind mismatch: expected %0d actual %0d",
                             $time, exp_r.kind, act.kind);
                if (exp_r.rtime != act.rtime)
                    $display("%0t time mismatch: expected %0d actual %0d",
                             $time, exp_r.rtime, act.rtime);
                if (exp_r.last != act.last)
                    $display("%0t last mismatch: expected %0d actual %0d",
                             $time, exp_r.last, act.last);
                if (exp_r != act) errors++;
            end
        end
        if (cycles > 2000000) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_request msg(input int id, input logic kind, input logic [1:0] flag,
                                     input logic [tpdt_pkg::TIME_W-1:0] ex,
                                     input logic [tpdt_pkg::TIME_W-1:0] wl);
        return {1'b0, 6'(id), kind, flag, ex, wl};
    endfunction

    function automatic t_request tick(input logic [tpdt_pkg::TIME_W-1:0] wl);
        return {1'b1, 6'($urandom), 1'($urandom), 2'($urandom),
                48'({$urandom, $urandom}), wl};
    endfunction

    // wait for the block to drain, then hold off for the scan latency
    task automatic drain();
        while (pending_q.size() > 0 || start || busy || reports_q.size() > 0)
            @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    // write one register, then hold off requests with the enable low
    task automatic write_reg(input logic [tpdt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tpdt_pkg::CFG_W-1:0] val);
        cfg_active = 1;
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == tpdt_pkg::REG_ROT) rot_q = val;
        else if (idx == tpdt_pkg::REG_MISS) miss_q = val;
        else if (idx == tpdt_pkg::REG_PROM) prom_q = val;
        @(posedge i_clk);
        cfg_active = 0;
    endtask

    // random phase: a pool of ids, times advancing near a base
    task automatic random_phase(input int count, input logic [tpdt_pkg::TIME_W-1:0] base);
        logic [tpdt_pkg::TIME_W-1:0] wall;
        logic [tpdt_pkg::TIME_W-1:0] lat;
        int n, pool;
        wall = base;
        pool = $urandom_range(4, 64);
        for (n = 0; n < count; n++) begin
            wall = wall + 48'($urandom_range(0, 3000));
            lat = 48'($urandom_range(0, 500));
            case ($urandom_range(0, 9))
                0: add_req(tick(wall + 48'($urandom_range(0, 1)) * {$urandom, 16'h0}));
                1, 2: add_req(tick(wall));
                3: add_req(msg($urandom_range(0, 63), 1'($urandom), 2'($urandom),
                               48'({$urandom, $urandom}), 48'({$urandom, $urandom})));
                default: add_req(msg($urandom_range(0, pool - 1), 1'($urandom),
                                     2'($urandom_range(0, 1)), wall - lat, wall));
            endcase
        end
        add_req(tick(wall));
    endtask

    initial begin
        rot_q = tpdt_pkg::ROT_RST;
        miss_q = tpdt_pkg::MISS_RST;
        prom_q = tpdt_pkg::PROM_RST;
        offset_q = '0;
        for (int i = 0; i < tpdt_pkg::TRACKS_DEF; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_hits[i] = '0;
            tbl_time[i] = '0;
            tbl_kind[i] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, empty tick, ignored flags, extremes
        add_req(tick('0));
        add_req(msg(0, 1'b0, tpdt_pkg::FLAG_NEW, '0, '0));
        add_req(msg(63, 1'b1, tpdt_pkg::FLAG_CORR, '1, '1));
        add_req(msg(5, 1'b0, 2'd2, 48'd5, 48'd9));
        add_req(msg(6, 1'b0, 2'd3, 48'd5, 48'd9));
        add_req(tick('1));
        drain();
        write_reg(tpdt_pkg::REG_ROT, 16'd1);
        write_reg(tpdt_pkg::REG_MISS, 16'd0);
        write_reg(tpdt_pkg::REG_PROM, 16'd0);
        add_req(msg(3, 1'b0, tpdt_pkg::FLAG_NEW, 48'd100, 48'd50));
        add_req(msg(7, 1'b1, tpdt_pkg::FLAG_NEW, 48'd200, 48'd150));
        add_req(msg(3, 1'b0, tpdt_pkg::FLAG_CORR, 48'd300, 48'd250));
        add_req(tick(48'd250));
        add_req(tick(48'd251));
        add_req(msg(3, 1'b0, tpdt_pkg::FLAG_NEW, 48'd10, '1));
        add_req(tick('0));
        add_req(tick('1));
        drain();
        write_reg(tpdt_pkg::REG_ROT, '1);
        write_reg(tpdt_pkg::REG_MISS, '1);
        write_reg(tpdt_pkg::REG_PROM, '1);
        for (int i = 0; i < 64; i++) add_req(msg(i, 1'b0, tpdt_pkg::FLAG_NEW, 48'd1, 48'd1));
        add_req(tick('1));
        drain();

        // random phases over several settings
        write_reg(tpdt_pkg::REG_ROT, 16'd10);
        write_reg(tpdt_pkg::REG_MISS, 16'd50);
        write_reg(tpdt_pkg::REG_PROM, 16'd2);
        random_phase(105, 48'({$urandom, $urandom}));
        drain();
        write_reg(tpdt_pkg::REG_ROT, 16'($urandom_range(1, 100)));
        write_reg(tpdt_pkg::REG_MISS, 16'($urandom_range(1, 100)));
        write_reg(tpdt_pkg::REG_PROM, 16'($urandom_range(0, 4)));
        random_phase(105, '1 - 48'd500000);
        drain();
        write_reg(tpdt_pkg::REG_ROT, 16'd3);
        write_reg(tpdt_pkg::REG_MISS, 16'd300);
        write_reg(tpdt_pkg::REG_PROM, 16'd1);
        quiet = 1;
        random_phase(105, 48'd0);
        drain();

        $display("sent %0d requests, %0d check ticks, %0d reports compared",
                 n_sent, n_ticks, n_reports);
        if (errors == 0 && reports_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
